FILE: sv/decimal_text_to_integer_unit_defines.svh
// ----------------------------------------------------------------------------
// Decimal text to integer unit: assertion macros
// Shared property forms for the checker, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_INTEGER_UNIT_DEFINES_SVH
`define DECIMAL_TEXT_TO_INTEGER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DTTI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DTTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dtti_pkg.sv
// ----------------------------------------------------------------------------
// Decimal text to integer package
// Phase codes, character codes, register indexes and the record handed
// from the parser to the range check.
// ----------------------------------------------------------------------------
`default_nettype none

package dtti_pkg;

  // Width of the accumulated magnitude and of the result value.
  localparam int unsigned MAG_W = 64;
  localparam int unsigned PHASE_W = 3;

  // Parser phases.
  localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SPACE  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ENDED  = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Configuration register indexes.
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SIGNED_MODE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDE_MODE   = 1'd1;

  // Value mask for the 32-bit range.
  localparam logic [MAG_W-1:0] NARROW_MASK = 64'h0000_0000_FFFF_FFFF;

  // Parser state at the end of a string, with the modes in force.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               negative;
    logic [MAG_W-1:0]   magnitude;
    logic               overflowed;
    logic               rejected;
    logic               signed_mode;
    logic               wide_mode;
  } snap_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

FILE: sv/dtti_parse.sv
// ----------------------------------------------------------------------------
// Decimal text to integer parser
// Registers each incoming item, walks the string state one character per
// cycle unless a string's last item waits on a full hand-off slot, and
// hands the final state of a string to the range check.
`default_nettype none

module dtti_parse (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                signed_mode,
  input  wire logic                wide_mode,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          ch,
  input  wire logic                has_char,
  input  wire logic                last,
  output logic                     snap_valid,
  input  wire logic                snap_ready,
  output dtti_pkg::snap_t          snap
);

  // Input register.
  logic       a_valid;
  logic [7:0] a_ch;
  logic       a_has;
  logic       a_last;
  logic       a_fire;

  // String state.
  logic [dtti_pkg::PHASE_W-1:0] phase;
  logic [dtti_pkg::PHASE_W-1:0] phase_next;
  logic                         negative;
  logic                         negative_next;
  logic [dtti_pkg::MAG_W-1:0]   magnitude;
  logic [dtti_pkg::MAG_W-1:0]   magnitude_next;
  logic                         overflowed;
  logic                         overflowed_next;
  logic                         rejected;
  logic                         rejected_next;

  // Digit accumulation.
  logic [dtti_pkg::MAG_W+3:0]   prod;
  logic [dtti_pkg::MAG_W-1:0]   dig_mag;
  logic                         dig_ovf;
  logic                         lead_bad;

  // An item moves on unless it ends a string and the hand-off slot is full.
  assign a_fire   = a_valid && (!a_last || !snap_valid || snap_ready);
  assign in_ready = !a_valid || a_fire;

  // Magnitude times ten plus the digit, with four guard bits for overflow.
  assign prod = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0}
              + {{dtti_pkg::MAG_W{1'b0}}, a_ch[3:0]};
  assign dig_ovf = overflowed || (prod[dtti_pkg::MAG_W+3:dtti_pkg::MAG_W] != 4'd0);
  assign dig_mag = dig_ovf ? {dtti_pkg::MAG_W{1'b1}} : prod[dtti_pkg::MAG_W-1:0];

  // A leading space, or a leading minus in unsigned mode, is refused.
  assign lead_bad = (phase == dtti_pkg::PH_START) &&
                    ((a_ch == dtti_pkg::CH_SPACE) ||
                     ((a_ch == dtti_pkg::CH_MINUS) && !signed_mode));

  // Next string state for the character in the input register.
  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    magnitude_next  = magnitude;
    overflowed_next = overflowed;
    rejected_next   = rejected;
    if (a_has && !rejected && (phase != dtti_pkg::PH_ENDED)) begin
      if (a_ch == dtti_pkg::CH_NUL) begin
        // A NUL ends the text; it needs digits before it.
        if (phase != dtti_pkg::PH_DIGITS) begin
          rejected_next = 1'b1;
        end
        phase_next = dtti_pkg::PH_ENDED;
      end else begin
        unique case (phase) inside
          dtti_pkg::PH_START, dtti_pkg::PH_SPACE: begin
            if (lead_bad) begin
              rejected_next = 1'b1;
            end else if (dtti_pkg::is_space(a_ch)) begin
              phase_next = dtti_pkg::PH_SPACE;
            end else if ((a_ch == dtti_pkg::CH_PLUS) || (a_ch == dtti_pkg::CH_MINUS)) begin
              negative_next = (a_ch == dtti_pkg::CH_MINUS);
              phase_next    = dtti_pkg::PH_SIGN;
            end else if (dtti_pkg::is_digit(a_ch)) begin
              magnitude_next  = dig_mag;
              overflowed_next = dig_ovf;
              phase_next      = dtti_pkg::PH_DIGITS;
            end else begin
              rejected_next = 1'b1;
            end
          end
          dtti_pkg::PH_SIGN, dtti_pkg::PH_DIGITS: begin
            if (dtti_pkg::is_digit(a_ch)) begin
              magnitude_next  = dig_mag;
              overflowed_next = dig_ovf;
              phase_next      = dtti_pkg::PH_DIGITS;
            end else begin
              rejected_next = 1'b1;
            end
          end
          default: begin
            rejected_next = 1'b1;
          end
        endcase
      end
    end
  end

  // Control registers: input valid, string state and hand-off valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      snap_valid <= 1'b0;
      phase      <= dtti_pkg::PH_START;
      negative   <= 1'b0;
      magnitude  <= '0;
      overflowed <= 1'b0;
      rejected   <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_fire && a_last) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (a_fire) begin
        if (a_last) begin
          // The string is done: start clean for the next one.
          phase      <= dtti_pkg::PH_START;
          negative   <= 1'b0;
          magnitude  <= '0;
          overflowed <= 1'b0;
          rejected   <= 1'b0;
        end else begin
          phase      <= phase_next;
          negative   <= negative_next;
          magnitude  <= magnitude_next;
          overflowed <= overflowed_next;
          rejected   <= rejected_next;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      a_ch   <= ch;
      a_has  <= has_char;
      a_last <= last;
    end
    if (a_fire && a_last) begin
      snap.phase       <= phase_next;
      snap.negative    <= negative_next;
      snap.magnitude   <= magnitude_next;
      snap.overflowed  <= overflowed_next;
      snap.rejected    <= rejected_next;
      snap.signed_mode <= signed_mode;
      snap.wide_mode   <= wide_mode;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dtti_finish.sv
// ----------------------------------------------------------------------------
// Decimal text to integer range check
// Checks the final magnitude against the selected range, applies the sign
// and holds the result item in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtti_finish (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      snap_valid,
  output logic                           snap_ready,
  input  wire dtti_pkg::snap_t           snap,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [dtti_pkg::MAG_W-1:0]     value,
  output logic                           ok
);

  logic [dtti_pkg::MAG_W-1:0] mask;
  logic [dtti_pkg::MAG_W-1:0] pos_max;
  logic [dtti_pkg::MAG_W-1:0] limit;
  logic [dtti_pkg::MAG_W-1:0] neg_mag;
  logic                       ok_c;
  logic [dtti_pkg::MAG_W-1:0] value_c;

  assign snap_ready = !out_valid || out_ready;

  // Range limit: one more on the negative side in signed mode.
  assign mask    = snap.wide_mode ? {dtti_pkg::MAG_W{1'b1}} : dtti_pkg::NARROW_MASK;
  assign pos_max = snap.signed_mode ? (mask >> 1) : mask;
  assign limit   = pos_max + {{(dtti_pkg::MAG_W-1){1'b0}},
                              (snap.signed_mode && snap.negative)};
  assign neg_mag = {dtti_pkg::MAG_W{1'b0}} - snap.magnitude;

  // Success needs digits, no rejection or overflow, and a magnitude in range.
  assign ok_c = !snap.rejected && !snap.overflowed &&
                ((snap.phase == dtti_pkg::PH_DIGITS) || (snap.phase == dtti_pkg::PH_ENDED)) &&
                (snap.magnitude <= limit);
  assign value_c = ok_c ? ((snap.negative ? neg_mag : snap.magnitude) & mask)
                        : {dtti_pkg::MAG_W{1'b0}};

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      value <= value_c;
      ok    <= ok_c;
    end
  end

endmodule

`default_nettype wire

FILE: sv/decimal_text_to_integer_unit.sv
// ----------------------------------------------------------------------------
// Decimal text to integer unit
// Strict base-10 conversion of a character stream to a 32- or 64-bit integer.
// ----------------------------------------------------------------------------
// The unit takes one character per item and sustains one item per clock
// cycle while the output is not stalled. The item with last is taken into
// the input register at acceptance; the string's result item then passes
// the parser's hand-off register and the output register, and is held back
// while the output is stalled. The per-character step is one
// multiply-by-ten-and-add with an overflow check, done in the parser stage;
// the range check and sign are applied in the following stage. Registers
// signed_mode and wide_mode must be written only while no string is in flight.
`default_nettype none

module decimal_text_to_integer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [dtti_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic                                cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [7:0]                          ch,
  input  wire logic                                has_char,
  input  wire logic                                last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [dtti_pkg::MAG_W-1:0]               value,
  output logic                                     ok
);

  logic            signed_mode;
  logic            wide_mode;
  logic            snap_valid;
  logic            snap_ready;
  dtti_pkg::snap_t snap;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b1;
      wide_mode   <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dtti_pkg::REG_SIGNED_MODE: signed_mode <= cfg_wdata;
        dtti_pkg::REG_WIDE_MODE:   wide_mode   <= cfg_wdata;
      endcase
    end
  end

  // Character parser.
  dtti_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .signed_mode (signed_mode),
    .wide_mode   (wide_mode),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .has_char    (has_char),
    .last        (last),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap        (snap)
  );

  // Range check and output register.
  dtti_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .ok         (ok)
  );

endmodule

`default_nettype wire

FILE: sv/dtti_checker.sv
// ----------------------------------------------------------------------------
// Decimal text to integer checker
// Port-level properties of the unit, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_text_to_integer_unit_defines.svh"

module dtti_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [dtti_pkg::MAG_W-1:0]      value,
  input wire logic                            ok
);

  // A stalled result item holds its payload.
  `DTTI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(ok), "result item changed while stalled")

  // A failed conversion reports a zero value.
  `DTTI_ASSERT_NOW(a_err_zero, out_valid && !ok, value == '0, "failed item carries a nonzero value")

  // Nothing is offered right after reset.
  `DTTI_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "result item present after reset")

  // With the output empty the pipeline drains and input is taken.
  `DTTI_ASSERT_NOW(a_ready_empty, !out_valid, in_ready, "input stalled with the output empty")

endmodule

bind decimal_text_to_integer_unit dtti_checker u_dtti_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value),
  .ok        (ok)
);

`default_nettype wire
